FILE: rtl/schema_source_tokenizer_unit_assert.svh
// Assertion macros for the schema source tokenizer.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef SCHEMA_SOURCE_TOKENIZER_UNIT_ASSERT_SVH
`define SCHEMA_SOURCE_TOKENIZER_UNIT_ASSERT_SVH

// Implication in the same cycle.
`define STU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle.
`define STU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/stu_pkg.sv
// Shared types, codes and character constants of the schema source tokenizer.
// No dependencies.
package stu_pkg;

  localparam int OFFSET_BITS = 24;
  localparam int LINE_BITS   = 24;

  typedef enum logic [3:0] {
    K_IDENT    = 4'd0,
    K_INT      = 4'd1,
    K_FLOAT    = 4'd2,
    K_STRING   = 4'd3,
    K_DOC      = 4'd4,
    K_PUNCT    = 4'd5,
    K_END      = 4'd6,
    K_ECOMMENT = 4'd7,
    K_ESTRING  = 4'd8
  } token_kind_t;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UE     = 8'h45;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] BOM_0     = 8'hEF;
  localparam logic [7:0] BOM_1     = 8'hBB;
  localparam logic [7:0] BOM_2     = 8'hBF;

  typedef struct packed {
    logic       alpha;
    logic       digit;
    logic       hexc;
    logic       nl;
    logic       blank;
    logic [1:0] extra;   // continuation bytes of a UTF-8 lead byte
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eot;
    byte_class_t cls;
  } q_entry_t;

  typedef struct packed {
    token_kind_t            kind;
    logic [OFFSET_BITS-1:0] s;
    logic [OFFSET_BITS-1:0] e;
    logic [OFFSET_BITS-1:0] ts;
    logic [OFFSET_BITS-1:0] te;
    logic [LINE_BITS-1:0]   line;
    logic [OFFSET_BITS-1:0] col;
    logic                   nl;
    logic                   sp;
  } token_t;

  function automatic byte_class_t classify(logic [7:0] b);
    byte_class_t c;
    c.alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
    c.digit = (b >= CH_ZERO && b <= 8'h39);
    c.hexc  = c.digit || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
    c.nl    = (b == CH_NL);
    c.blank = (b == CH_SP) || (b == CH_TAB) || (b == CH_CR);
    if (b[7] == 1'b0)          c.extra = 2'd0;
    else if (b[7:5] == 3'b110) c.extra = 2'd1;
    else if (b[7:4] == 4'hE)   c.extra = 2'd2;
    else if (b[7:3] == 5'h1E)  c.extra = 2'd3;
    else                       c.extra = 2'd0;
    return c;
  endfunction

endpackage

FILE: rtl/stu_front.sv
// Front end: accepts input items, classifies each byte and queues it.
// Depends on stu_pkg.
module stu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        source_byte,
  input  logic              end_of_text,
  output stu_pkg::q_entry_t q_head,
  output logic              q_valid,
  input  logic              q_pop
);
  import stu_pkg::*;

  logic [1:0] count;
  q_entry_t   slot0;
  q_entry_t   slot1;
  q_entry_t   incoming;
  logic       push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_head   = slot0;

  always_comb begin
    incoming.data = source_byte;
    incoming.eot  = end_of_text;
    incoming.cls  = classify(source_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && q_pop) begin
        if (count == 2'd1) begin
          slot0 <= incoming;
        end else begin
          slot0 <= slot1;
          slot1 <= incoming;
        end
      end else if (push) begin
        count <= count + 2'd1;
        if (count == 2'd0) slot0 <= incoming;
        else slot1 <= incoming;
      end else if (q_pop) begin
        count <= count - 2'd1;
        slot0 <= slot1;
      end
    end
  end

endmodule

FILE: rtl/stu_back.sv
// Back end: lexer state machine, replay list for backtracking and token output.
// Depends on stu_pkg; fed by stu_front.
module stu_back (
  input  logic              clk,
  input  logic              rst,
  input  stu_pkg::q_entry_t q_head,
  input  logic              q_valid,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output stu_pkg::token_t   out_tok,
  output logic              out_last
);
  import stu_pkg::*;

  localparam int OB = OFFSET_BITS;

  typedef enum logic [22:0] {
    M_BOM       = 23'd1 << 0,
    M_BOMSEQ    = 23'd1 << 1,
    M_IDLE      = 23'd1 << 2,
    M_IDENT     = 23'd1 << 3,
    M_ZERO      = 23'd1 << 4,
    M_DEC       = 23'd1 << 5,
    M_HEX       = 23'd1 << 6,
    M_DOT       = 23'd1 << 7,
    M_FRAC      = 23'd1 << 8,
    M_EXP       = 23'd1 << 9,
    M_EXPSIGN   = 23'd1 << 10,
    M_EXPDIG    = 23'd1 << 11,
    M_SLASH     = 23'd1 << 12,
    M_SL2       = 23'd1 << 13,
    M_LINE      = 23'd1 << 14,
    M_DOC2      = 23'd1 << 15,
    M_DOC       = 23'd1 << 16,
    M_BLOCK     = 23'd1 << 17,
    M_BLOCKSTAR = 23'd1 << 18,
    M_STR       = 23'd1 << 19,
    M_STRESC    = 23'd1 << 20,
    M_MINUS     = 23'd1 << 21,
    M_UTF8      = 23'd1 << 22
  } lex_mode_t;

  typedef enum logic [1:0] {
    FS_PUSH = 2'd0,
    FS_FAIL = 2'd1,
    FS_END  = 2'd2
  } flag_src_t;

  typedef struct packed {
    q_entry_t       ent;
    logic [OB-1:0]  off;
  } work_t;

  lex_mode_t             mode, mode_next;
  logic [OB-1:0]         boff, boff_next;
  logic [LINE_BITS-1:0]  cline, cline_next;
  logic [OB-1:0]         lstart, lstart_next;
  logic                  nlf, nlf_next;
  logic                  spf, spf_next;
  q_entry_t              pend0, pend0_next;
  q_entry_t              pend1, pend1_next;
  logic [OB-1:0]         tbeg, tbeg_next;
  logic [LINE_BITS-1:0]  tline, tline_next;
  logic [OB-1:0]         tcol, tcol_next;
  logic                  flt, flt_next;
  logic [OB-1:0]         docb, docb_next;
  logic [1:0]            u8, u8_next;
  work_t                 wl [3];
  work_t                 wl_next [3];
  logic [1:0]            wcnt, wcnt_next;
  logic                  h_valid;
  token_t                h_tok;
  logic                  flush;

  work_t                 cur;
  logic                  from_q;
  logic                  have_cur;
  logic                  out_free;
  logic                  fire;
  logic                  flush_set;
  logic                  emit;
  logic                  redo;
  logic                  bt;
  token_t                tok;
  flag_src_t             efs;

  assign from_q   = (wcnt == 2'd0);
  assign have_cur = !from_q || q_valid;
  assign out_free = !out_valid || out_ready;
  assign fire     = have_cur && !flush && (!emit || !h_valid || out_free);
  assign q_pop    = fire && from_q;
  assign flush_set = fire && (wcnt_next == 2'd0) && (emit || h_valid);

  always_comb begin
    cur = from_q ? work_t'{ent: q_head, off: boff} : wl[0];
  end

  always_comb begin
    logic [7:0]    b;
    byte_class_t   c;
    logic [OB-1:0] off;
    logic [OB-1:0] nx;
    logic [OB-1:0] tb1;
    logic [OB-1:0] tb3;
    logic [OB-1:0] s;
    logic [1:0]    dec;
    logic          n2;

    b   = cur.ent.data;
    c   = cur.ent.cls;
    off = cur.off;
    nx  = off + OB'(1);
    tb1 = tbeg + OB'(1);
    tb3 = tbeg + OB'(3);
    n2  = (mode == M_EXPSIGN);
    s   = off - (n2 ? OB'(2) : OB'(1));
    dec = (u8 != 2'd0) ? u8 - 2'd1 : 2'd0;

    mode_next   = mode;
    boff_next   = (from_q && !cur.ent.eot) ? boff + OB'(1) : boff;
    cline_next  = cline;
    lstart_next = lstart;
    nlf_next    = nlf;
    spf_next    = spf;
    pend0_next  = pend0;
    pend1_next  = pend1;
    tbeg_next   = tbeg;
    tline_next  = tline;
    tcol_next   = tcol;
    flt_next    = flt;
    docb_next   = docb;
    u8_next     = u8;
    emit = 1'b0;
    redo = 1'b0;
    bt   = 1'b0;
    efs  = FS_PUSH;
    tok.kind = K_IDENT;
    tok.s    = tbeg;
    tok.e    = off;
    tok.ts   = tbeg;
    tok.te   = off;
    tok.line = tline;
    tok.col  = tcol;
    tok.nl   = nlf;
    tok.sp   = spf;

    if (cur.ent.eot) begin
      case (mode)
        M_IDENT: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
        end
        M_ZERO, M_DEC, M_HEX, M_FRAC, M_EXPDIG: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          tok.kind = flt ? K_FLOAT : K_INT;
        end
        M_DOT, M_EXP, M_EXPSIGN: begin
          bt = 1'b1;
        end
        M_SLASH, M_MINUS: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          tok.kind = K_PUNCT; tok.e = tb1; tok.te = tb1;
        end
        M_UTF8, M_BOMSEQ: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          tok.kind = K_PUNCT;
        end
        M_DOC2: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          tok.kind = K_DOC; tok.ts = tb3; tok.te = tb3;
        end
        M_DOC: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          tok.kind = K_DOC; tok.ts = docb;
          tok.te = (pend0.data == CH_CR) ? off - OB'(1) : off;
        end
        M_BLOCK, M_BLOCKSTAR: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          tok.kind = K_ECOMMENT; efs = FS_FAIL;
        end
        M_STR, M_STRESC: begin
          emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          tok.kind = K_ESTRING; efs = FS_FAIL;
        end
        default: begin
          // flush done: emit End and start a new text
          emit = 1'b1; efs = FS_END;
          tok.kind = K_END; tok.s = off; tok.ts = off;
          tok.line = cline; tok.col = off - lstart + OB'(1);
          tok.nl = 1'b1; tok.sp = 1'b1;
          mode_next   = M_BOM;
          boff_next   = '0;
          cline_next  = LINE_BITS'(1);
          lstart_next = '0;
          nlf_next    = 1'b1;
          spf_next    = 1'b1;
          tbeg_next   = '0;
          tline_next  = LINE_BITS'(1);
          tcol_next   = OB'(1);
          flt_next    = 1'b0;
          docb_next   = '0;
          u8_next     = 2'd0;
        end
      endcase
    end else begin
      case (mode)
        M_BOM: begin
          if (b == BOM_0) begin
            tbeg_next = off; tline_next = cline; tcol_next = off - lstart + OB'(1);
            u8_next = 2'd2; mode_next = M_BOMSEQ;
          end else begin
            mode_next = M_IDLE; redo = 1'b1;
          end
        end
        M_BOMSEQ: begin
          if (b == ((u8 == 2'd2) ? BOM_1 : BOM_2)) begin
            u8_next = u8 - 2'd1;
            if (u8 == 2'd1) begin
              lstart_next = nx; mode_next = M_IDLE;
            end
          end else begin
            u8_next = dec;
            if (dec == 2'd0) begin
              emit = 1'b1; tok.kind = K_PUNCT; tok.e = nx; tok.te = nx;
              mode_next = M_IDLE;
            end else begin
              mode_next = M_UTF8;
            end
          end
        end
        M_IDLE: begin
          if (c.nl) begin
            cline_next = cline + LINE_BITS'(1); lstart_next = nx;
            nlf_next = 1'b1; spf_next = 1'b1;
          end else if (c.blank) begin
            spf_next = 1'b1;
          end else begin
            tbeg_next = off; tline_next = cline; tcol_next = off - lstart + OB'(1);
            if (b == CH_SLASH) mode_next = M_SLASH;
            else if (c.alpha) mode_next = M_IDENT;
            else if (c.digit) begin
              flt_next = 1'b0;
              mode_next = (b == CH_ZERO) ? M_ZERO : M_DEC;
            end else if (b == CH_QUOTE) mode_next = M_STR;
            else if (b == CH_MINUS) mode_next = M_MINUS;
            else if (c.extra == 2'd0) begin
              emit = 1'b1; tok.kind = K_PUNCT;
              tok.s = off; tok.ts = off; tok.e = nx; tok.te = nx;
              tok.line = cline; tok.col = off - lstart + OB'(1);
            end else begin
              u8_next = c.extra; mode_next = M_UTF8;
            end
          end
        end
        M_IDENT: begin
          if (!(c.alpha || c.digit)) begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
          end
        end
        M_ZERO: begin
          if (b == CH_X || b == CH_UX) mode_next = M_HEX;
          else begin
            mode_next = M_DEC; redo = 1'b1;
          end
        end
        M_DEC: begin
          if (c.digit || b == CH_UNDER) begin
            mode_next = M_DEC;
          end else if (b == CH_DOT || b == CH_E || b == CH_UE) begin
            pend0_next = cur.ent;
            mode_next = (b == CH_DOT) ? M_DOT : M_EXP;
          end else begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = flt ? K_FLOAT : K_INT;
          end
        end
        M_HEX: begin
          if (!(c.hexc || b == CH_UNDER)) begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = flt ? K_FLOAT : K_INT;
          end
        end
        M_DOT: begin
          if (c.digit) begin
            flt_next = 1'b1; mode_next = M_FRAC;
          end else bt = 1'b1;
        end
        M_FRAC: begin
          if (c.digit) begin
            mode_next = M_FRAC;
          end else if (b == CH_E || b == CH_UE) begin
            pend0_next = cur.ent; mode_next = M_EXP;
          end else begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = flt ? K_FLOAT : K_INT;
          end
        end
        M_EXP: begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            pend1_next = cur.ent; mode_next = M_EXPSIGN;
          end else if (c.digit) begin
            flt_next = 1'b1; mode_next = M_EXPDIG;
          end else bt = 1'b1;
        end
        M_EXPSIGN: begin
          if (c.digit) begin
            flt_next = 1'b1; mode_next = M_EXPDIG;
          end else bt = 1'b1;
        end
        M_EXPDIG: begin
          if (!c.digit) begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = flt ? K_FLOAT : K_INT;
          end
        end
        M_SLASH: begin
          if (b == CH_SLASH) mode_next = M_SL2;
          else if (b == CH_STAR) mode_next = M_BLOCK;
          else begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = K_PUNCT; tok.e = tb1; tok.te = tb1;
          end
        end
        M_SL2: begin
          if (b == CH_SLASH) mode_next = M_DOC2;
          else begin
            spf_next = 1'b1;
            if (c.nl) begin
              mode_next = M_IDLE; redo = 1'b1;
            end else mode_next = M_LINE;
          end
        end
        M_LINE: begin
          if (c.nl) begin
            mode_next = M_IDLE; redo = 1'b1;
          end
        end
        M_DOC2: begin
          if (b == CH_SLASH) begin
            spf_next = 1'b1; mode_next = M_LINE;
          end else if (c.nl) begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = K_DOC; tok.ts = tb3; tok.te = tb3;
          end else begin
            docb_next  = tb3 + ((b == CH_SP) ? OB'(1) : OB'(0));
            pend0_next = cur.ent;
            mode_next  = M_DOC;
          end
        end
        M_DOC: begin
          if (c.nl) begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = K_DOC; tok.ts = docb;
            tok.te = (pend0.data == CH_CR) ? off - OB'(1) : off;
          end else pend0_next = cur.ent;
        end
        M_BLOCK, M_BLOCKSTAR: begin
          if (mode == M_BLOCKSTAR && b == CH_SLASH) begin
            spf_next = 1'b1; mode_next = M_IDLE;
          end else begin
            if (c.nl) begin
              cline_next = cline + LINE_BITS'(1); lstart_next = nx; nlf_next = 1'b1;
            end
            mode_next = (b == CH_STAR) ? M_BLOCKSTAR : M_BLOCK;
          end
        end
        M_STR: begin
          if (b == CH_BSLASH) mode_next = M_STRESC;
          else if (b == CH_QUOTE) begin
            emit = 1'b1; mode_next = M_IDLE;
            tok.kind = K_STRING; tok.e = nx; tok.te = nx;
          end else if (c.nl) begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = K_ESTRING; efs = FS_FAIL;
          end
        end
        M_STRESC: begin
          if (c.nl) begin
            emit = 1'b1; redo = 1'b1; mode_next = M_IDLE;
            tok.kind = K_ESTRING; efs = FS_FAIL;
          end else mode_next = M_STR;
        end
        M_MINUS: begin
          emit = 1'b1; mode_next = M_IDLE; tok.kind = K_PUNCT;
          if (b == CH_GT) begin
            tok.e = nx; tok.te = nx;
          end else begin
            redo = 1'b1; tok.e = tb1; tok.te = tb1;
          end
        end
        M_UTF8: begin
          u8_next = dec;
          if (dec == 2'd0) begin
            emit = 1'b1; mode_next = M_IDLE;
            tok.kind = K_PUNCT; tok.e = nx; tok.te = nx;
          end
        end
        default: begin
          mode_next = M_IDLE; redo = 1'b1;
        end
      endcase
    end

    // backtrack: close the number before the held bytes, then replay them
    if (bt) begin
      emit = 1'b1; mode_next = M_IDLE;
      tok.kind = flt ? K_FLOAT : K_INT;
      tok.e = s; tok.te = s;
    end

    if (efs == FS_FAIL) begin
      tok.nl = 1'b0; tok.sp = 1'b0;
    end
    if (emit && efs == FS_PUSH) begin
      nlf_next = 1'b0; spf_next = 1'b0;
    end

    wl_next[0] = wl[0];
    wl_next[1] = wl[1];
    wl_next[2] = wl[2];
    wcnt_next  = wcnt;
    if (bt) begin
      wl_next[0] = '{ent: pend0, off: s};
      if (n2) begin
        wl_next[1] = '{ent: pend1, off: s + OB'(1)};
        wl_next[2] = cur;
        wcnt_next  = 2'd3;
      end else begin
        wl_next[1] = cur;
        wcnt_next  = 2'd2;
      end
    end else if (redo) begin
      if (from_q) begin
        wl_next[0] = cur;
        wcnt_next  = 2'd1;
      end
    end else if (!from_q) begin
      wl_next[0] = wl[1];
      wl_next[1] = wl[2];
      wcnt_next  = wcnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_BOM;
      boff      <= '0;
      cline     <= LINE_BITS'(1);
      lstart    <= '0;
      nlf       <= 1'b1;
      spf       <= 1'b1;
      tbeg      <= '0;
      tline     <= LINE_BITS'(1);
      tcol      <= OB'(1);
      flt       <= 1'b0;
      docb      <= '0;
      u8        <= 2'd0;
      wcnt      <= 2'd0;
      h_valid   <= 1'b0;
      flush     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // release the held token as the last one of its item
      if (flush && out_free) begin
        out_tok   <= h_tok;
        out_last  <= 1'b1;
        out_valid <= 1'b1;
        h_valid   <= 1'b0;
        flush     <= 1'b0;
      end else if (fire && emit && h_valid) begin
        out_tok   <= h_tok;
        out_last  <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        mode   <= mode_next;
        boff   <= boff_next;
        cline  <= cline_next;
        lstart <= lstart_next;
        nlf    <= nlf_next;
        spf    <= spf_next;
        pend0  <= pend0_next;
        pend1  <= pend1_next;
        tbeg   <= tbeg_next;
        tline  <= tline_next;
        tcol   <= tcol_next;
        flt    <= flt_next;
        docb   <= docb_next;
        u8     <= u8_next;
        wl[0]  <= wl_next[0];
        wl[1]  <= wl_next[1];
        wl[2]  <= wl_next[2];
        wcnt   <= wcnt_next;
        if (emit) begin
          h_tok   <= tok;
          h_valid <= 1'b1;
        end
        if (flush_set) flush <= 1'b1;
      end
    end
  end

endmodule

FILE: rtl/schema_source_tokenizer_unit.sv
// Schema source tokenizer: one byte per input item, end_of_text closes the text and
// yields End. Each byte goes through the lexer step of the back end; a token that ends
// on the following byte has that byte lexed again, a number backtrack replays up to
// three bytes through the lexer step, and an item that yields tokens releases its
// final token in a separate flush step. The two-entry input queue lets bytes arrive
// while the back end works or waits on out_ready.
// Depends on stu_pkg, stu_front, stu_back and the assertion header.
`include "schema_source_tokenizer_unit_assert.svh"

module schema_source_tokenizer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [15:0]                     write_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      source_byte,
  input  logic                            end_of_text,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      token_kind,
  output logic [stu_pkg::OFFSET_BITS-1:0] start_offset,
  output logic [stu_pkg::OFFSET_BITS-1:0] end_offset,
  output logic [stu_pkg::OFFSET_BITS-1:0] text_start,
  output logic [stu_pkg::OFFSET_BITS-1:0] text_end,
  output logic [stu_pkg::LINE_BITS-1:0]   line_number,
  output logic [stu_pkg::OFFSET_BITS-1:0] column_number,
  output logic [15:0]                     file_tag,
  output logic                            at_line_start,
  output logic                            after_space,
  output logic                            last_result
);
  import stu_pkg::*;

  logic [15:0] file_number;
  q_entry_t    q_head;
  logic        q_valid;
  logic        q_pop;
  token_t      out_tok;

  always_ff @(posedge clk) begin
    if (rst) file_number <= 16'd0;
    else if (write_enable) file_number <= write_data;
  end

  stu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .source_byte(source_byte),
    .end_of_text(end_of_text),
    .q_head     (q_head),
    .q_valid    (q_valid),
    .q_pop      (q_pop)
  );

  stu_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_head   (q_head),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tok  (out_tok),
    .out_last (last_result)
  );

  assign token_kind    = out_tok.kind;
  assign start_offset  = out_tok.s;
  assign end_offset    = out_tok.e;
  assign text_start    = out_tok.ts;
  assign text_end      = out_tok.te;
  assign line_number   = out_tok.line;
  assign column_number = out_tok.col;
  assign file_tag      = file_number;
  assign at_line_start = out_tok.nl;
  assign after_space   = out_tok.sp;

  `STU_ASSERT_NOW(a_full_not_empty, !in_ready, q_valid, "queue full but head invalid")
  `STU_ASSERT_NOW(a_end_is_last, out_valid && token_kind == K_END, last_result,
                  "End token not last of its item")
  `STU_ASSERT_NOW(a_error_flags, out_valid && (token_kind == K_ECOMMENT || token_kind == K_ESTRING),
                  !at_line_start && !after_space, "error token carries flags")

endmodule

FILE: verif/schema_source_tokenizer_unit_tb.sv
// Self-checking testbench for the schema source tokenizer: random and directed texts,
// a token-level predictor with its own lexer state, and randomized handshake stalls.
// Depends on stu_pkg and the schema_source_tokenizer_unit RTL.
`timescale 1ns / 1ps

module schema_source_tokenizer_unit_tb;
  import stu_pkg::*;

  typedef enum int {
    MD_BOM, MD_BOMSEQ, MD_IDLE, MD_IDENT, MD_ZERO, MD_DEC, MD_HEX, MD_DOT, MD_FRAC,
    MD_EXP, MD_EXPSIGN, MD_EXPDIG, MD_SLASH, MD_SL2, MD_LINE, MD_DOC2, MD_DOC,
    MD_BLOCK, MD_BLOCKSTAR, MD_STR, MD_STRESC, MD_MINUS, MD_UTF8
  } lex_mode_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [23:0] s;
    logic [23:0] e;
    logic [23:0] ts;
    logic [23:0] te;
    logic [23:0] line;
    logic [23:0] col;
    logic [15:0] tag;
    logic        nl;
    logic        sp;
    logic        last;
  } token_rec_t;

  localparam int MAX_TOKENS_PER_ITEM = 5;

  class token_scoreboard;
    logic [15:0] file_num;
    logic [23:0] pos, cur_line, line_base, tok_start, tok_line, tok_col, doc_start;
    bit          nl_seen, sp_seen, is_float;
    lex_mode_e   mode;
    logic [7:0]  held[3];
    int          u8_left;
    token_rec_t  step_toks[$];
    token_rec_t  pending_tokens[$];
    int          mismatches;
    int          tokens_checked;
    int          kind_seen[16];

    function new();
      file_num = '0;
      mismatches = 0;
      tokens_checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      clear();
    endfunction

    function void clear();
      pos = '0; cur_line = 24'd1; line_base = '0;
      nl_seen = 1'b1; sp_seen = 1'b1; mode = MD_BOM;
      held[0] = 8'h00; held[1] = 8'h00; held[2] = 8'h00;
      tok_start = '0; tok_line = 24'd1; tok_col = 24'd1;
      is_float = 1'b0; doc_start = '0; u8_left = 0;
    endfunction

    function bit is_alpha(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
    endfunction
    function bit is_digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction
    function bit is_hex(logic [7:0] b);
      return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction
    function int utf8_len(logic [7:0] b);
      if (!b[7]) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'hE) return 3;
      if (b[7:3] == 5'h1E) return 4;
      return 1;
    endfunction

    function void emit(token_kind_t k, logic [23:0] s, logic [23:0] e, logic [23:0] ts,
                       logic [23:0] te, logic [23:0] ln, logic [23:0] col, bit nl, bit sp);
      token_rec_t t;
      if (step_toks.size() >= MAX_TOKENS_PER_ITEM) return;
      t = '{kind: k, s: s, e: e, ts: ts, te: te, line: ln, col: col, tag: file_num,
            nl: nl, sp: sp, last: 1'b0};
      step_toks.insert(step_toks.size(), t);
    endfunction

    function void push_tok(token_kind_t k, logic [23:0] s, logic [23:0] e,
                           logic [23:0] ts, logic [23:0] te);
      emit(k, s, e, ts, te, tok_line, tok_col, nl_seen, sp_seen);
      nl_seen = 1'b0;
      sp_seen = 1'b0;
    endfunction

    function void open_error(token_kind_t k, logic [23:0] e);
      emit(k, tok_start, e, tok_start, e, tok_line, tok_col, 1'b0, 1'b0);
    endfunction

    function void start_tok(logic [23:0] o);
      tok_start = o;
      tok_line = cur_line;
      tok_col = o - line_base + 24'd1;
    endfunction

    function void next_line(logic [23:0] o);
      cur_line = cur_line + 24'd1;
      line_base = o + 24'd1;
      nl_seen = 1'b1;
    endfunction

    function void end_number(logic [23:0] e);
      push_tok(is_float ? K_FLOAT : K_INT, tok_start, e, tok_start, e);
      mode = MD_IDLE;
    endfunction

    function void doc_end(logic [23:0] stop);
      logic [23:0] te;
      te = (held[0] == CH_CR) ? stop - 24'd1 : stop;
      push_tok(K_DOC, tok_start, stop, doc_start, te);
      mode = MD_IDLE;
    endfunction

    function void utf8_take(logic [23:0] o);
      if (u8_left > 0) u8_left--;
      if (u8_left == 0) begin
        push_tok(K_PUNCT, tok_start, o + 24'd1, tok_start, o + 24'd1);
        mode = MD_IDLE;
      end
    endfunction

    // Emit the number up to before the held bytes, then relex them.
    function void rewind(logic [23:0] now);
      int n;
      logic [23:0] s;
      logic [7:0] h0, h1;
      n = (mode == MD_EXPSIGN) ? 2 : 1;
      s = now - 24'(n);
      h0 = held[0];
      h1 = held[1];
      end_number(s);
      lex(h0, s);
      if (n == 2) lex(h1, s + 24'd1);
    endfunction

    function void lex(logic [7:0] b, logic [23:0] o);
      logic [23:0] nx;
      nx = o + 24'd1;
      case (mode)
        MD_BOM: begin
          if (b == BOM_0) begin
            start_tok(o); u8_left = 2; mode = MD_BOMSEQ;
          end else begin
            mode = MD_IDLE; lex(b, o);
          end
        end
        MD_BOMSEQ: begin
          if (b == ((u8_left == 2) ? BOM_1 : BOM_2)) begin
            u8_left--;
            if (u8_left == 0) begin
              line_base = nx; mode = MD_IDLE;
            end
          end else begin
            mode = MD_UTF8; utf8_take(o);
          end
        end
        MD_IDLE: begin
          if (b == CH_NL) begin
            next_line(o); sp_seen = 1'b1;
          end else if (b == CH_SP || b == CH_TAB || b == CH_CR) begin
            sp_seen = 1'b1;
          end else begin
            start_tok(o);
            if (b == CH_SLASH) mode = MD_SLASH;
            else if (is_alpha(b)) mode = MD_IDENT;
            else if (is_digit(b)) begin
              is_float = 1'b0; mode = (b == CH_ZERO) ? MD_ZERO : MD_DEC;
            end else if (b == CH_QUOTE) mode = MD_STR;
            else if (b == CH_MINUS) mode = MD_MINUS;
            else if (utf8_len(b) == 1) push_tok(K_PUNCT, o, nx, o, nx);
            else begin
              u8_left = utf8_len(b) - 1; mode = MD_UTF8;
            end
          end
        end
        MD_IDENT: begin
          if (!(is_alpha(b) || is_digit(b))) begin
            push_tok(K_IDENT, tok_start, o, tok_start, o);
            mode = MD_IDLE; lex(b, o);
          end
        end
        MD_ZERO: begin
          if (b == CH_X || b == CH_UX) mode = MD_HEX;
          else begin
            mode = MD_DEC; lex(b, o);
          end
        end
        MD_DEC: begin
          if (is_digit(b) || b == CH_UNDER) ;
          else if (b == CH_DOT || b == CH_E || b == CH_UE) begin
            held[0] = b; mode = (b == CH_DOT) ? MD_DOT : MD_EXP;
          end else begin
            end_number(o); lex(b, o);
          end
        end
        MD_HEX: begin
          if (!(is_hex(b) || b == CH_UNDER)) begin
            end_number(o); lex(b, o);
          end
        end
        MD_DOT: begin
          if (is_digit(b)) begin
            is_float = 1'b1; mode = MD_FRAC;
          end else begin
            rewind(o); lex(b, o);
          end
        end
        MD_FRAC: begin
          if (is_digit(b)) ;
          else if (b == CH_E || b == CH_UE) begin
            held[0] = b; mode = MD_EXP;
          end else begin
            end_number(o); lex(b, o);
          end
        end
        MD_EXP: begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            held[1] = b; mode = MD_EXPSIGN;
          end else if (is_digit(b)) begin
            is_float = 1'b1; mode = MD_EXPDIG;
          end else begin
            rewind(o); lex(b, o);
          end
        end
        MD_EXPSIGN: begin
          if (is_digit(b)) begin
            is_float = 1'b1; mode = MD_EXPDIG;
          end else begin
            rewind(o); lex(b, o);
          end
        end
        MD_EXPDIG: begin
          if (!is_digit(b)) begin
            end_number(o); lex(b, o);
          end
        end
        MD_SLASH: begin
          if (b == CH_SLASH) mode = MD_SL2;
          else if (b == CH_STAR) mode = MD_BLOCK;
          else begin
            push_tok(K_PUNCT, tok_start, tok_start + 24'd1, tok_start, tok_start + 24'd1);
            mode = MD_IDLE; lex(b, o);
          end
        end
        MD_SL2: begin
          if (b == CH_SLASH) mode = MD_DOC2;
          else begin
            sp_seen = 1'b1; mode = MD_LINE;
            if (b == CH_NL) begin
              mode = MD_IDLE; lex(b, o);
            end
          end
        end
        MD_LINE: begin
          if (b == CH_NL) begin
            mode = MD_IDLE; lex(b, o);
          end
        end
        MD_DOC2: begin
          if (b == CH_SLASH) begin
            sp_seen = 1'b1; mode = MD_LINE;
          end else if (b == CH_NL) begin
            push_tok(K_DOC, tok_start, o, tok_start + 24'd3, tok_start + 24'd3);
            mode = MD_IDLE; lex(b, o);
          end else begin
            doc_start = tok_start + 24'd3 + ((b == CH_SP) ? 24'd1 : 24'd0);
            held[0] = b; mode = MD_DOC;
          end
        end
        MD_DOC: begin
          if (b == CH_NL) begin
            doc_end(o); lex(b, o);
          end else held[0] = b;
        end
        MD_BLOCK, MD_BLOCKSTAR: begin
          if (mode == MD_BLOCKSTAR && b == CH_SLASH) begin
            sp_seen = 1'b1; mode = MD_IDLE;
          end else begin
            if (b == CH_NL) next_line(o);
            mode = (b == CH_STAR) ? MD_BLOCKSTAR : MD_BLOCK;
          end
        end
        MD_STR: begin
          if (b == CH_BSLASH) mode = MD_STRESC;
          else if (b == CH_QUOTE) begin
            push_tok(K_STRING, tok_start, nx, tok_start, nx); mode = MD_IDLE;
          end else if (b == CH_NL) begin
            open_error(K_ESTRING, o); mode = MD_IDLE; lex(b, o);
          end
        end
        MD_STRESC: begin
          if (b == CH_NL) begin
            open_error(K_ESTRING, o); mode = MD_IDLE; lex(b, o);
          end else mode = MD_STR;
        end
        MD_MINUS: begin
          if (b == CH_GT) begin
            push_tok(K_PUNCT, tok_start, nx, tok_start, nx); mode = MD_IDLE;
          end else begin
            push_tok(K_PUNCT, tok_start, tok_start + 24'd1, tok_start, tok_start + 24'd1);
            mode = MD_IDLE; lex(b, o);
          end
        end
        MD_UTF8: utf8_take(o);
        default: begin
          mode = MD_IDLE; lex(b, o);
        end
      endcase
    endfunction

    function void flush(logic [23:0] now);
      case (mode)
        MD_IDENT: push_tok(K_IDENT, tok_start, now, tok_start, now);
        MD_ZERO, MD_DEC, MD_HEX, MD_FRAC, MD_EXPDIG: end_number(now);
        MD_DOT, MD_EXP, MD_EXPSIGN: begin
          rewind(now); flush(now);
        end
        MD_SLASH, MD_MINUS:
          push_tok(K_PUNCT, tok_start, tok_start + 24'd1, tok_start, tok_start + 24'd1);
        MD_UTF8, MD_BOMSEQ: push_tok(K_PUNCT, tok_start, now, tok_start, now);
        MD_DOC2: push_tok(K_DOC, tok_start, now, tok_start + 24'd3, tok_start + 24'd3);
        MD_DOC: doc_end(now);
        MD_BLOCK, MD_BLOCKSTAR: open_error(K_ECOMMENT, now);
        MD_STR, MD_STRESC: open_error(K_ESTRING, now);
        default: ;
      endcase
      mode = MD_IDLE;
    endfunction

    function void note_input(logic [7:0] b, bit eot);
      step_toks.delete();
      if (eot) begin
        flush(pos);
        emit(K_END, pos, pos, pos, pos, cur_line, pos - line_base + 24'd1, 1'b1, 1'b1);
        clear();
      end else begin
        lex(b, pos);
        pos = pos + 24'd1;
      end
      if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
      foreach (step_toks[i]) begin
        pending_tokens.insert(pending_tokens.size(), step_toks[i]);
        kind_seen[step_toks[i].kind]++;
      end
    endfunction

    function void check_result(token_rec_t got);
      token_rec_t want;
      tokens_checked++;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected no token, got kind=%0d start=%0d", got.kind, got.s);
        return;
      end
      want = pending_tokens.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: token mismatch at %0t", $realtime);
          $display("  exp kind=%0d s=%0d e=%0d ts=%0d te=%0d ln=%0d col=%0d tag=%h nl=%b sp=%b last=%b",
                   want.kind, want.s, want.e, want.ts, want.te, want.line, want.col,
                   want.tag, want.nl, want.sp, want.last);
          $display("  got kind=%0d s=%0d e=%0d ts=%0d te=%0d ln=%0d col=%0d tag=%h nl=%b sp=%b last=%b",
                   got.kind, got.s, got.e, got.ts, got.te, got.line, got.col,
                   got.tag, got.nl, got.sp, got.last);
        end
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        write_enable;
  logic [15:0] write_data;
  logic        in_valid, in_ready;
  logic [7:0]  source_byte;
  logic        end_of_text;
  logic        out_valid, out_ready;
  logic [3:0]  token_kind;
  logic [23:0] start_offset, end_offset, text_start, text_end;
  logic [23:0] line_number, column_number;
  logic [15:0] file_tag;
  logic        at_line_start, after_space, last_result;

  schema_source_tokenizer_unit uut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .write_data(write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .source_byte(source_byte), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_kind(token_kind), .start_offset(start_offset), .end_offset(end_offset),
    .text_start(text_start), .text_end(text_end),
    .line_number(line_number), .column_number(column_number),
    .file_tag(file_tag), .at_line_start(at_line_start), .after_space(after_space),
    .last_result(last_result)
  );

  token_scoreboard tokens = new();

  int tx_idle_pct, rx_idle_pct;
  bit long_hold_req, long_hold_done;
  int hold_left;
  int stall_cycles;
  int items_sent;
  logic [8:0] text_items[$];   // bit 8 marks end of text

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: check every accepted token, stall at random or for one long hold.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        tokens.check_result('{kind: token_kind, s: start_offset, e: end_offset,
                              ts: text_start, te: text_end, line: line_number,
                              col: column_number, tag: file_tag, nl: at_line_start,
                              sp: after_space, last: last_result});
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 20000) begin
      $display("ERROR: no progress for %0d cycles", stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_items.insert(text_items.size(), {1'b0, s[i]});
  endtask

  task automatic add_byte(logic [7:0] b);
    text_items.insert(text_items.size(), {1'b0, b});
  endtask

  task automatic add_end();
    text_items.insert(text_items.size(), 9'h100);
  endtask

  // Build one random text out of lexically meaningful fragments plus noise.
  task automatic add_random_text(int frags);
    int n;
    for (int f = 0; f < frags; f++) begin
      case ($urandom_range(15))
        0: add_str("id_9x");
        1: add_str($sformatf("%0d_%0d", $urandom_range(999), $urandom_range(9)));
        2: add_str($urandom_range(1) ? "0x1F_a" : "0Xbe");
        3: add_str($urandom_range(1) ? "3.25e-7" : "9.0E12");
        4: begin
          case ($urandom_range(3))
            0: add_str("1.");
            1: add_str("2e");
            2: add_str("4E+");
            default: add_str("5.5e-");
          endcase
        end
        5: add_str($urandom_range(1) ? "\"ab\\\"c\"" : "\"open\n");
        6: add_str($urandom_range(1) ? "// note\n" : "//\n");
        7: add_str($urandom_range(1) ? "/// doc text\r\n" : "///x\n");
        8: add_str($urandom_range(1) ? "/* a*\n*/" : "////\n");
        9: add_str($urandom_range(1) ? "->" : "-");
        10: begin
          n = $urandom_range(3) + 1;
          add_byte((n == 1) ? 8'hC3 : (n == 2) ? 8'hE2 : 8'hF0);
          repeat (n) add_byte(8'h80 | 8'($urandom_range(63)));
        end
        11: add_str($urandom_range(1) ? " \t" : "\n");
        12: add_str($urandom_range(1) ? "{};" : "/=");
        13: add_str("\r\n");
        default: add_byte(8'($urandom_range(255)));
      endcase
      if ($urandom_range(2) == 0) add_byte(CH_SP);
    end
    if ($urandom_range(7) == 0) add_str($urandom_range(1) ? "/* open" : "\"x\\");
    add_end();
  endtask

  task automatic send_items(int pressure_at);
    logic [8:0] it;
    while (text_items.size() > 0) begin
      it = text_items.pop_front();
      if (items_sent == pressure_at) long_hold_req = 1;
      source_byte <= it[7:0];
      end_of_text <= it[8];
      in_valid    <= 1'b1;
      do @(posedge clk); while (!in_ready);
      tokens.note_input(it[7:0], it[8]);
      items_sent++;
      if ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(4) + 1) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Hold until every token has come back, then let the back end settle.
  task automatic drain();
    while (tokens.pending_tokens.size() > 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_file_number(logic [15:0] v);
    write_enable <= 1'b1;
    write_data   <= v;
    @(posedge clk);
    tokens.file_num = v;
    write_enable <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    write_enable = 1'b0;
    write_data = 16'h0;
    in_valid = 1'b0;
    source_byte = 8'h0;
    end_of_text = 1'b0;
    tx_idle_pct = 8;
    rx_idle_pct = 78;
    long_hold_req = 0;
    long_hold_done = 0;
    hold_left = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: BOM, number forms and backtracks, strings, comments, punct, UTF-8.
    write_file_number(16'hFFFF);
    add_byte(BOM_0); add_byte(BOM_1); add_byte(BOM_2);
    add_str("a_9 0X_f 1.2e-3 1.x 7e+\n"); add_end();
    add_str("\"q\\\"\n/// d\r\n/*"); add_end();
    add_str("->-/ "); add_byte(8'hC3); add_byte(8'hA9);
    add_byte(8'hFF); add_byte(8'h00); add_byte(8'hE2); add_byte(CH_NL); add_end();
    add_byte(BOM_0); add_str("z"); add_end();
    add_str("0x"); add_end();
    send_items(-1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 78 : 0;
      rx_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 8 : 0;
      write_file_number((phase == 0) ? 16'h0000 : 16'($urandom_range(65535)));
      for (int t = 0; t < 2; t++) add_random_text($urandom_range(10) + 6);
      send_items((phase == 2) ? items_sent + 20 : -1);
      drain();
    end

    $display("Sent %0d items over four register settings; checked %0d tokens",
             items_sent, tokens.tokens_checked);
    $display("Tokens by kind: id %0d int %0d flt %0d str %0d doc %0d punct %0d end %0d err %0d",
             tokens.kind_seen[K_IDENT], tokens.kind_seen[K_INT], tokens.kind_seen[K_FLOAT],
             tokens.kind_seen[K_STRING], tokens.kind_seen[K_DOC], tokens.kind_seen[K_PUNCT],
             tokens.kind_seen[K_END],
             tokens.kind_seen[K_ECOMMENT] + tokens.kind_seen[K_ESTRING]);
    if (tokens.mismatches == 0 && tokens.pending_tokens.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
